// ===== src/template_marker_scanner_unit_macros.svh =====
// Assertion macros shared by the marker scanner RTL.
`ifndef TEMPLATE_MARKER_SCANNER_UNIT_MACROS_SVH
`define TEMPLATE_MARKER_SCANNER_UNIT_MACROS_SVH

// Condition implies property in the same cycle.
`define TMS_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Condition implies property in the next cycle.
`define TMS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/tms_pkg.sv =====
// Types, constants and byte helpers for the marker scanner.
package tms_pkg;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UZ    = 8'h5A;

   localparam logic [3:0] POS_IDLE     = 4'd0;
   localparam logic [3:0] POS_DIGIT_HI = 4'd6;
   localparam logic [3:0] POS_DIGIT_LO = 4'd7;
   localparam logic [3:0] POS_CLOSE    = 4'd9;

   localparam int unsigned TDATA_W = 24;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } tms_digit_type;

   // controller -> datapath
   typedef struct packed {
      logic take;
      logic replay_emit;
      logic replay_finish;
   } tms_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic needs_replay;
      logic replay_done;
   } tms_sts_type;

   function automatic tms_digit_type digit_value(input logic [7:0] c);
      tms_digit_type d;
      d.hit   = 1'b0;
      d.value = 6'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d.hit   = 1'b1;
         d.value = 6'(c - CH_ZERO);
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d.hit   = 1'b1;
         d.value = 6'(c - CH_UA + 8'd10);
      end else if (c >= CH_LA && c <= CH_LX) begin
         d.hit   = 1'b1;
         d.value = 6'(c - CH_LA + 8'd36);
      end
      return d;
   endfunction

   function automatic logic [7:0] digit_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd10) begin
         r = CH_ZERO + {2'b00, v};
      end else if (v < 6'd36) begin
         r = CH_UA + {2'b00, v} - 8'd10;
      end else if (v < 6'd60) begin
         r = CH_LA + {2'b00, v} - 8'd36;
      end else begin
         r = CH_LX;
      end
      return r;
   endfunction

   // fixed marker byte expected at a position; digit slots give zero
   function automatic logic [7:0] fixed_byte(input logic [3:0] p);
      logic [7:0] r;
      case (p)
         4'd0, 4'd9: r = CH_SLASH;
         4'd1, 4'd8: r = CH_STAR;
         4'd2, 4'd4: r = CH_AT;
         4'd3, 4'd5: r = CH_QUERY;
         default:    r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== src/tms_ctrl.sv =====
// Controller: scan / replay sequencing and the request handshake.
module tms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tms_pkg::tms_sts_type sts,
   output tms_pkg::tms_cmd_type cmd
);
   import tms_pkg::*;

   localparam logic ST_SCAN   = 1'b0;
   localparam logic ST_REPLAY = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      req_tready        = (state_ff == ST_SCAN) && sts.out_free;
      cmd.take          = req_tready && req_tvalid;
      cmd.replay_emit   = (state_ff == ST_REPLAY) && sts.out_free && !sts.replay_done;
      cmd.replay_finish = (state_ff == ST_REPLAY) && sts.out_free && sts.replay_done;
      state_in          = state_ff;
      case (state_ff)
         ST_SCAN: begin
            if (cmd.take && sts.needs_replay) begin
               state_in = ST_REPLAY;
            end
         end
         ST_REPLAY: begin
            if (cmd.replay_finish) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/tms_dpath.sv =====
// Datapath: match position, digit store, replay index and output register.
`include "template_marker_scanner_unit_macros.svh"

module tms_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_byte,
   input  logic                req_last,
   input  tms_pkg::tms_cmd_type cmd,
   output tms_pkg::tms_sts_type sts,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [tms_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);
   import tms_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  idx_ff, idx_in;
   logic [5:0]  dig_hi_ff, dig_hi_in;
   logic [5:0]  dig_lo_ff, dig_lo_in;
   logic [7:0]  held_ff, held_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [11:0] out_code_ff, out_code_in;
   logic        out_last_ff, out_last_in;

   tms_digit_type dig;
   logic        at_digit, ext_digit, ext_fixed, complete, mismatch, load;
   logic [11:0] code_val;
   logic [7:0]  replay_byte;

   always_comb begin
      dig       = digit_value(req_byte);
      at_digit  = (pos_ff == POS_DIGIT_HI) || (pos_ff == POS_DIGIT_LO);
      ext_digit = at_digit && dig.hit;
      ext_fixed = !at_digit && (pos_ff < POS_CLOSE) && (req_byte == fixed_byte(pos_ff));
      complete  = (pos_ff == POS_CLOSE) && (req_byte == CH_SLASH);
      mismatch  = !(ext_digit || ext_fixed || complete);
      // hi * 60 + lo as hi * 64 - hi * 4 + lo
      code_val  = 12'({dig_hi_ff, 6'b0}) - 12'({dig_hi_ff, 2'b0}) + 12'(dig_lo_ff);

      if (idx_ff == POS_DIGIT_HI) begin
         replay_byte = digit_char(dig_hi_ff);
      end else if (idx_ff == POS_DIGIT_LO) begin
         replay_byte = digit_char(dig_lo_ff);
      end else begin
         replay_byte = fixed_byte(idx_ff);
      end

      sts.out_free     = !out_valid_ff || rsp_tready;
      sts.needs_replay = mismatch && (pos_ff != POS_IDLE);
      sts.replay_done  = (idx_ff == pos_ff);

      load = (cmd.take && !(ext_digit || ext_fixed)) || cmd.replay_emit || cmd.replay_finish;

      pos_in      = pos_ff;
      idx_in      = idx_ff;
      dig_hi_in   = dig_hi_ff;
      dig_lo_in   = dig_lo_ff;
      held_in     = held_ff;
      out_kind_in = out_kind_ff;
      out_byte_in = out_byte_ff;
      out_code_in = out_code_ff;
      out_last_in = out_last_ff;

      if (cmd.take) begin
         if (ext_digit || ext_fixed) begin
            if (ext_digit && pos_ff == POS_DIGIT_HI) begin
               dig_hi_in = dig.value;
            end else if (ext_digit) begin
               dig_lo_in = dig.value;
            end
            pos_in = req_last ? POS_IDLE : pos_ff + 4'd1;
         end else if (complete) begin
            out_kind_in = 1'b1;
            out_byte_in = 8'h00;
            out_code_in = code_val;
            out_last_in = 1'b1;
            pos_in      = POS_IDLE;
         end else if (pos_ff == POS_IDLE) begin
            out_kind_in = 1'b0;
            out_byte_in = req_byte;
            out_code_in = 12'd0;
            out_last_in = 1'b1;
         end else begin
            // break-off: open the replay with the leading slash
            out_kind_in = 1'b0;
            out_byte_in = CH_SLASH;
            out_code_in = 12'd0;
            out_last_in = 1'b0;
            held_in     = req_byte;
            idx_in      = 4'd1;
         end
      end else if (cmd.replay_emit) begin
         out_kind_in = 1'b0;
         out_byte_in = replay_byte;
         out_code_in = 12'd0;
         out_last_in = 1'b0;
         idx_in      = idx_ff + 4'd1;
      end else if (cmd.replay_finish) begin
         out_kind_in = 1'b0;
         out_byte_in = held_ff;
         out_code_in = 12'd0;
         out_last_in = 1'b1;
         pos_in      = POS_IDLE;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_IDLE;
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_hi_ff   <= dig_hi_in;
      dig_lo_ff   <= dig_lo_in;
      held_ff     <= held_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - 20){1'b0}}, out_code_ff, out_byte_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   `TMS_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_CLOSE, "match position out of range")
   `TMS_ASSERT_NEXT(a_code_out, clock, reset, cmd.take && complete, out_valid_ff && out_kind_ff && out_last_ff, "marker code not presented")
   `TMS_ASSERT_NOW(a_replay_idx, clock, reset, cmd.replay_emit, idx_ff < pos_ff && idx_ff != 4'd0, "replay index outside prefix")
   `TMS_ASSERT_NEXT(a_replay_end, clock, reset, cmd.replay_finish, out_valid_ff && !out_kind_ff && out_last_ff && pos_ff == POS_IDLE, "replay did not close run")

endmodule

// ===== src/template_marker_scanner_unit.sv =====
// Top level of the template marker scanner.
//
// Scans a text byte stream for the marker "/*@?@?" + two base-60 digits + "*/".
// Request channel (req_*): one text byte per request, tlast marks the final byte
// of the text. Response channel (rsp_*): literal bytes (tuser = 0) and decoded
// marker codes (tuser = 1, code = first digit * 60 + second digit); tlast is
// set on the last response caused by a request.
// Latency: responses are registered; the first response to a request appears
// the cycle after the request is taken. Throughput: one request per cycle while
// the receiver keeps up and bytes extend a marker, pass through as literals or
// close a marker. When a partial marker of n bytes (at most nine) breaks off,
// the n bytes are replayed and then the breaking byte follows, one response a
// cycle while the receiver keeps up; tms_ctrl sequences the replay and holds
// off requests. A partial marker still open at a tlast byte is dropped silently.
// Reset (synchronous, active high) clears the match position and empties the
// output register. When the receiver stalls, the output register holds its
// response and a new request is taken only once that register drains.
module template_marker_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [19:8] marker_code, [23:20] zero
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // run_last
);
   import tms_pkg::*;

   tms_cmd_type cmd;
   tms_sts_type sts;

   // sequencing: accept, replay stepping and run close
   tms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // matching, digit store and the response register
   tms_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
